>>> rtl/zpwd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package zpwd_pkg;

  // Payload word layout and fixed patterns
  localparam int unsigned WordWidth        = 16;
  localparam logic [15:0] HeaderPattern    = 16'hA000;
  localparam logic [15:0] HeaderMask       = 16'hFFFC;
  localparam logic [15:0] SkipMarker       = 16'hA000;
  localparam logic [5:0]  ColumnXor        = 6'h3C;

  // Acceptance window of a hit
  localparam int unsigned RowLimit         = 960;
  localparam int unsigned ColumnLimit      = 192;

  // Packed port widths
  localparam int unsigned InDataWidth      = 16;
  localparam int unsigned InUserWidth      = 2;
  localparam int unsigned OutDataWidth     = 48;
  localparam int unsigned OutUserWidth     = 4;

  // Position inside the frame, one-hot
  typedef enum logic [2:0] {
    POS_IDLE   = 3'b001,
    POS_SECOND = 3'b010,
    POS_BODY   = 3'b100
  } word_pos_e;

  // One decoded hit
  typedef struct packed {
    logic       header_error;
    logic [8:0] folded_row;
    logic       second_sample;
    logic       first_hit;
    logic       in_range;
    logic [5:0] common_mode;
    logic [7:0] pixel_value;
    logic [7:0] pixel_column;
    logic [9:0] pixel_row;
  } hit_t;

  // Context of the frame that a hit is decoded against
  typedef struct packed {
    logic [1:0] chip_id;
    logic [9:0] row_base;
    logic [5:0] common_mode;
    logic       first;
    logic       header_error;
  } hit_ctx_t;

endpackage

`default_nettype wire

>>> rtl/zpwd_hit_map.sv
`timescale 1ns / 1ps
`default_nettype none

module zpwd_hit_map (
  input  logic [15:0]       word_i,
  input  zpwd_pkg::hit_ctx_t ctx_i,
  output zpwd_pkg::hit_t    hit_o
);
  import zpwd_pkg::*;

  logic [9:0] row;
  logic [5:0] col_x;
  logic [7:0] col;

  // Row from base plus row bit, wrapping in ten bits
  assign row   = ctx_i.row_base + {9'd0, word_i[14]};

  // Column: flip the pattern bits, chip id fills the top two bits
  assign col_x = word_i[13:8] ^ ColumnXor;
  assign col   = {ctx_i.chip_id, col_x};

  always_comb begin
    hit_o.pixel_row     = row;
    hit_o.pixel_column  = col;
    hit_o.pixel_value   = word_i[7:0];
    hit_o.common_mode   = ctx_i.common_mode;
    hit_o.in_range      = ({1'b0, row} < 11'(RowLimit)) && ({1'b0, col} < 9'(ColumnLimit));
    hit_o.first_hit     = ctx_i.first;
    hit_o.second_sample = row[2];
    hit_o.folded_row    = {row[9:3], row[1:0]};
    hit_o.header_error  = ctx_i.header_error;
  end

endmodule

`default_nettype wire

>>> rtl/zero_suppressed_pixel_word_decoder_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Word contents
// s_axis    in         tdata: payload_word; tuser: frame_start, event_start
// m_axis    out        one word per hit; tdata: row, column, value, common mode,
//                      folded row; tuser: in_range, first_hit, second_sample,
//                      header_error
//
// One input word is taken every cycle while the skid stage is empty; each hit
// is registered when its word is accepted. Frame state and the output register
// sit behind a single level of decode logic. A one-word skid stage takes a hit
// while the output register is stalled, so s_axis_tready drops only when both
// are full. Reset clears frame state and empties both output stages.

module zero_suppressed_pixel_word_decoder_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // [15:0] payload_word
  input  logic [zpwd_pkg::InDataWidth-1:0]    s_axis_tdata,
  // [0] frame_start, [1] event_start
  input  logic [zpwd_pkg::InUserWidth-1:0]    s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // [9:0] pixel_row, [17:10] pixel_column, [25:18] pixel_value,
  // [31:26] common_mode, [40:32] folded_row, [47:41] zero
  output logic [zpwd_pkg::OutDataWidth-1:0]   m_axis_tdata,
  // [0] in_range, [1] first_hit, [2] second_sample, [3] header_error
  output logic [zpwd_pkg::OutUserWidth-1:0]   m_axis_tuser
);
  import zpwd_pkg::*;

  word_pos_e  pos_q, pos_d;
  logic [1:0] chip_q, chip_d;
  logic [9:0] row_base_q, row_base_d;
  logic [5:0] cm_q, cm_d;
  logic       skip_q, skip_d;
  logic       first_q, first_d;
  logic       bad_q, bad_d;

  hit_t       out_q, skid_q, hit;
  hit_ctx_t   ctx;
  logic       out_valid_q, skid_valid_q;

  logic [15:0] word;
  logic        frame_start, event_start;
  logic        in_fire, out_fire, is_hit;

  assign word        = s_axis_tdata;
  assign frame_start = s_axis_tuser[0];
  assign event_start = s_axis_tuser[1];

  assign s_axis_tready = !skid_valid_q;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign out_fire      = m_axis_tvalid && m_axis_tready;

  // Decode the word against the current frame state
  always_comb begin
    pos_d      = pos_q;
    chip_d     = chip_q;
    row_base_d = row_base_q;
    cm_d       = cm_q;
    skip_d     = skip_q;
    first_d    = first_q || event_start;
    bad_d      = bad_q;
    is_hit     = 1'b0;
    if (frame_start) begin
      bad_d      = bad_q || ((word & HeaderMask) != HeaderPattern);
      chip_d     = word[1:0];
      skip_d     = 1'b0;
      row_base_d = '0;
      cm_d       = '0;
      pos_d      = POS_SECOND;
    end else begin
      unique case (pos_q)
        POS_IDLE: begin
        end
        POS_SECOND: begin
          pos_d = POS_BODY;
        end
        POS_BODY: begin
          priority if (skip_q) begin
            skip_d = 1'b0;
          end else if (word == SkipMarker) begin
            skip_d = 1'b1;
          end else if (!word[15]) begin
            row_base_d = {word[14:6], 1'b0};
            cm_d       = word[5:0];
          end else begin
            is_hit  = 1'b1;
            first_d = 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign ctx.chip_id      = chip_q;
  assign ctx.row_base     = row_base_q;
  assign ctx.common_mode  = cm_q;
  assign ctx.first        = first_q || event_start;
  assign ctx.header_error = bad_q;

  zpwd_hit_map u_hit_map (
    .word_i (word),
    .ctx_i  (ctx),
    .hit_o  (hit)
  );

  // Advance frame state on each accepted word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q      <= POS_IDLE;
      chip_q     <= '0;
      row_base_q <= '0;
      cm_q       <= '0;
      skip_q     <= 1'b0;
      first_q    <= 1'b1;
      bad_q      <= 1'b0;
    end else if (in_fire) begin
      pos_q      <= pos_d;
      chip_q     <= chip_d;
      row_base_q <= row_base_d;
      cm_q       <= cm_d;
      skip_q     <= skip_d;
      first_q    <= first_d;
      bad_q      <= bad_d;
    end
  end

  // Output register and skid stage: control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (out_fire) skid_valid_q <= 1'b0;
    end else if (in_fire && is_hit) begin
      if (!out_valid_q || out_fire) out_valid_q  <= 1'b1;
      else                          skid_valid_q <= 1'b1;
    end else if (out_fire) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output register and skid stage: payload
  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_fire) out_q <= skid_q;
    end else if (in_fire && is_hit) begin
      if (!out_valid_q || out_fire) out_q  <= hit;
      else                          skid_q <= hit;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'd0, out_q.folded_row, out_q.common_mode, out_q.pixel_value,
                          out_q.pixel_column, out_q.pixel_row};
  assign m_axis_tuser  = {out_q.header_error, out_q.second_sample, out_q.first_hit,
                          out_q.in_range};

  // The skid stage only fills behind a full output register
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid stage full while output register empty");

  // A hit arriving at a stalled output lands in the skid stage
  a_hit_to_skid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && is_hit && out_valid_q && !m_axis_tready) |=> skid_valid_q)
    else $error("hit lost at stalled output");

  // A chip header always moves to the second word of the frame
  a_header_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && frame_start) |=> (pos_q == POS_SECOND))
    else $error("chip header did not restart the frame");

  // The error flag never clears once set
  a_bad_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bad_q |=> bad_q)
    else $error("header error flag cleared");

endmodule

`default_nettype wire

>>> dv/tb_zero_suppressed_pixel_word_decoder_unit.sv
`timescale 1ns / 1ps

module tb_zero_suppressed_pixel_word_decoder_unit;
  import zpwd_pkg::*;

  localparam int unsigned QuietLimit = 1000;
  localparam int unsigned TailCycles = 8;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  // [15:0] payload_word
  logic [15:0] s_axis_tdata  = '0;
  // [0] frame_start, [1] event_start
  logic [1:0]  s_axis_tuser  = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // [9:0] pixel_row, [17:10] pixel_column, [25:18] pixel_value,
  // [31:26] common_mode, [40:32] folded_row, [47:41] zero
  logic [47:0] m_axis_tdata;
  // [0] in_range, [1] first_hit, [2] second_sample, [3] header_error
  logic [3:0]  m_axis_tuser;

  // Decoder state as the block should hold it
  word_pos_e   frame_pos    = POS_IDLE;
  logic [1:0]  chip_sel     = '0;
  logic [9:0]  base_row     = '0;
  logic [5:0]  cm_latched   = '0;
  logic        skip_pending = 1'b0;
  logic        first_armed  = 1'b1;
  logic        header_bad   = 1'b0;

  hit_t        pending_hits[$];
  hit_t        want;

  int unsigned errors          = 0;
  int unsigned words_accepted  = 0;
  int unsigned hits_checked    = 0;
  int unsigned hits_outside    = 0;
  int unsigned first_hits      = 0;
  int unsigned quiet_cycles    = 0;
  int unsigned sink_wait       = 0;
  bit          src_idle_on     = 1'b1;
  bit          sink_idle_on    = 1'b1;

  zero_suppressed_pixel_word_decoder_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #5 clk_i = ~clk_i;

  function automatic int unsigned draw_idle(bit on);
    return on ? $urandom_range(0, 7) : 0;
  endfunction

  // Advance the decoder state by one word; queue the hit it yields, if any
  function automatic void decode_payload_word(logic [15:0] w, logic fs, logic es);
    logic [9:0] row;
    logic [7:0] col;
    hit_t       h;
    if (es) first_armed = 1'b1;
    if (fs) begin
      if ((w & HeaderMask) != HeaderPattern) header_bad = 1'b1;
      chip_sel     = w[1:0];
      skip_pending = 1'b0;
      base_row     = '0;
      cm_latched   = '0;
      frame_pos    = POS_SECOND;
      return;
    end
    if (frame_pos == POS_IDLE) return;
    if (frame_pos == POS_SECOND) begin
      frame_pos = POS_BODY;
      return;
    end
    if (skip_pending) begin
      skip_pending = 1'b0;
      return;
    end
    if (w == SkipMarker) begin
      skip_pending = 1'b1;
      return;
    end
    // Row header: base is twice the upper field
    if (!w[15]) begin
      base_row   = {w[14:6], 1'b0};
      cm_latched = w[5:0];
      return;
    end
    row = base_row + {9'd0, w[14]};
    col = {2'b00, w[13:8] ^ ColumnXor} + {chip_sel, 6'b000000};
    h.pixel_row     = row;
    h.pixel_column  = col;
    h.pixel_value   = w[7:0];
    h.common_mode   = cm_latched;
    h.in_range      = ({22'd0, row} < RowLimit) && ({24'd0, col} < ColumnLimit);
    h.first_hit     = first_armed;
    h.second_sample = row[2];
    h.folded_row    = 9'((row >> 3) * 4 + row % 4);
    h.header_error  = header_bad;
    first_armed = 1'b0;
    pending_hits = {pending_hits, h};
  endfunction

  function automatic void check_field(string name, int unsigned exp_v, int unsigned act_v);
    if (exp_v != act_v) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
      errors++;
    end
  endfunction

  // Check each hit word against the oldest prediction, then predict from each input word
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_hits.size() == 0) begin
          $error("hit word with nothing predicted: tdata %h tuser %h",
                 m_axis_tdata, m_axis_tuser);
          errors++;
        end else begin
          want = pending_hits.pop_front();
          hits_checked++;
          if (!want.in_range) hits_outside++;
          if (want.first_hit) first_hits++;
          check_field("pixel_row",     want.pixel_row,     m_axis_tdata[9:0]);
          check_field("pixel_column",  want.pixel_column,  m_axis_tdata[17:10]);
          check_field("pixel_value",   want.pixel_value,   m_axis_tdata[25:18]);
          check_field("common_mode",   want.common_mode,   m_axis_tdata[31:26]);
          check_field("folded_row",    want.folded_row,    m_axis_tdata[40:32]);
          check_field("tdata_pad",     0,                  m_axis_tdata[47:41]);
          check_field("in_range",      want.in_range,      m_axis_tuser[0]);
          check_field("first_hit",     want.first_hit,     m_axis_tuser[1]);
          check_field("second_sample", want.second_sample, m_axis_tuser[2]);
          check_field("header_error",  want.header_error,  m_axis_tuser[3]);
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        words_accepted++;
        decode_payload_word(s_axis_tdata, s_axis_tuser[0], s_axis_tuser[1]);
      end
    end
  end

  // Stall the output for a random number of cycles after each hit word
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) sink_wait = draw_idle(sink_idle_on);
      if (sink_wait > 0) begin
        m_axis_tready <= 1'b0;
        sink_wait--;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // End the run when neither side moves a word for too long
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= QuietLimit) begin
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  // Offer one word after a random gap and hold it until accepted
  task automatic send_word(logic [15:0] w, logic fs, logic es);
    int unsigned gap;
    gap = draw_idle(src_idle_on);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= w;
    s_axis_tuser  <= {es, fs};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // Drop valid and hold off until every predicted hit has come out
  task automatic hold_until_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_hits.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_words_before_frame();
    send_word(16'hFFFF, 1'b0, 1'b0);
    send_word(16'h8000, 1'b0, 1'b1);
    send_word(16'h0000, 1'b0, 1'b0);
  endtask

  task automatic test_row_and_hit_extremes();
    send_word(HeaderPattern, 1'b1, 1'b1);
    // second word would be a hit if it were not skipped
    send_word(16'hFFFF, 1'b0, 1'b0);
    send_word(16'h7FFF, 1'b0, 1'b0);
    send_word(16'hFFFF, 1'b0, 1'b0);
    send_word(16'h0000, 1'b0, 1'b0);
    send_word(16'h8000, 1'b0, 1'b0);
    // rows 959 and 960 either side of the limit
    send_word(16'h77C0, 1'b0, 1'b0);
    send_word(16'hC15A, 1'b0, 1'b0);
    send_word(16'h7800, 1'b0, 1'b0);
    send_word(16'h8A3C, 1'b0, 1'b1);
  endtask

  task automatic test_markers_and_restart();
    send_word(SkipMarker, 1'b0, 1'b0);
    send_word(16'hFFFF, 1'b0, 1'b0);
    send_word(16'hA001, 1'b0, 1'b0);
    // new frame in the middle of a body, chip 3, event mark on the same word
    send_word(HeaderPattern | 16'h0003, 1'b1, 1'b1);
    send_word(16'h1234, 1'b0, 1'b0);
    send_word(16'hBC55, 1'b0, 1'b0);
    send_word(16'h8300, 1'b0, 1'b0);
    // marker as the last body word; the next header clears the skip
    send_word(SkipMarker, 1'b0, 1'b0);
    send_word(HeaderPattern | 16'h0002, 1'b1, 1'b0);
    send_word(SkipMarker, 1'b0, 1'b0);
    send_word(16'hC0AA, 1'b0, 1'b0);
  endtask

  task automatic send_random_frame();
    int unsigned body_len;
    int unsigned pick;
    send_word(HeaderPattern | 16'($urandom_range(0, 3)), 1'b1, $urandom_range(0, 3) == 0);
    send_word(16'($urandom), 1'b0, 1'b0);
    body_len = $urandom_range(1, 24);
    repeat (body_len) begin
      pick = $urandom_range(0, 19);
      if (pick < 5) begin
        send_word({1'b0, 15'($urandom)}, 1'b0, $urandom_range(0, 7) == 0);
      end else if (pick == 5) begin
        send_word(SkipMarker, 1'b0, 1'b0);
      end else if (pick == 6) begin
        send_word(SkipMarker, 1'b0, 1'b0);
        send_word(16'($urandom), 1'b0, 1'b0);
      end else begin
        send_word({1'b1, 15'($urandom)}, 1'b0, $urandom_range(0, 7) == 0);
      end
    end
  endtask

  task automatic test_random_frames();
    bit drained;
    drained = 1'b0;
    while (words_accepted < 480) begin
      src_idle_on  = $urandom_range(0, 3) != 0;
      sink_idle_on = $urandom_range(0, 3) != 0;
      send_random_frame();
      if (!drained && words_accepted >= 240) begin
        hold_until_drained();
        drained = 1'b1;
      end
    end
    src_idle_on  = 1'b1;
    sink_idle_on = 1'b1;
  endtask

  task automatic test_bad_header();
    send_word(16'hA004, 1'b1, 1'b1);
    send_word(16'h5555, 1'b0, 1'b0);
    send_word(16'h8001, 1'b0, 1'b0);
    send_word(16'h2001, 1'b1, 1'b0);
    send_word(16'h0000, 1'b0, 1'b0);
    send_word(16'hFE7F, 1'b0, 1'b0);
  endtask

  task automatic test_random_noise();
    repeat (120) begin
      send_word(16'($urandom), $urandom_range(0, 7) == 0, $urandom_range(0, 7) == 0);
    end
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_words_before_frame();
    test_row_and_hit_extremes();
    test_markers_and_restart();
    test_random_frames();
    test_bad_header();
    test_random_noise();
    hold_until_drained();
    repeat (TailCycles) @(posedge clk_i);
    $display("Covered %0d payload words: idle, frame restarts, markers, bad headers.",
             words_accepted);
    $display("Checked %0d hits, %0d outside the window, %0d first of their event.",
             hits_checked, hits_outside, first_hits);
    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
